FILE: rtl/core/atan_pkg.sv
// shared constants and types for the arctangent series unit
package atan_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int MAG_W          = 29;
    localparam int ANGLE_W        = 30;
    localparam int TERM_W         = 16;
    localparam int TOL_W          = 29;
    localparam int DIV_W          = 64;
    localparam logic [ANGLE_W-1:0] HALF_PI    = 30'd421657428;
    localparam logic [ANGLE_W-1:0] QUARTER_PI = 30'd210828714;
    localparam logic [TOL_W-1:0]   TOL_RESET  = 29'd268;
    localparam logic [TERM_W-1:0]  CAP_RESET  = 16'd4096;

    localparam logic [0:0] REG_TOLERANCE = 1'd0;
    localparam logic [0:0] REG_TERM_CAP  = 1'd1;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQR,
        OP_INIT,
        OP_ADD,
        OP_MULX2,
        OP_MULODD,
        OP_DIVODD,
        OP_DIVX,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic is_one;
        logic recip;
        logic zero_arg;
        logic above_tol;
    } t_status;

endpackage

FILE: rtl/core/atan_div.sv
// restoring divider, one quotient bit per cycle
module atan_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [atan_pkg::DIV_W-1:0]  i_num,
    input  logic [atan_pkg::DIV_W-1:0]  i_den,
    output logic                        o_busy,
    output logic [atan_pkg::DIV_W-1:0]  o_quot
);
    localparam int CW = $clog2(atan_pkg::DIV_W + 1);

    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic [atan_pkg::DIV_W-1:0] r_q;
    logic [atan_pkg::DIV_W-1:0] r_den;
    logic [atan_pkg::DIV_W:0]   r_rem;
    logic [atan_pkg::DIV_W:0]   n_rem_sh;

    assign n_rem_sh = {r_rem[atan_pkg::DIV_W-1:0], r_q[atan_pkg::DIV_W-1]};
    assign o_busy   = r_busy;
    assign o_quot   = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(atan_pkg::DIV_W);
            r_q    <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (n_rem_sh >= {1'b0, r_den}) begin
                r_rem <= n_rem_sh - {1'b0, r_den};
                r_q   <= {r_q[atan_pkg::DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= n_rem_sh;
                r_q   <= {r_q[atan_pkg::DIV_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

FILE: rtl/core/atan_datapath.sv
// arctangent datapath: term magnitude, partial sum, counters and output register
module atan_datapath #(
    parameter int DATA_WIDTH = atan_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  atan_pkg::t_cmd                i_cmd,
    output atan_pkg::t_status             o_status,
    input  logic [DATA_WIDTH-1:0]         i_arg,
    input  logic [atan_pkg::TOL_W-1:0]    i_tol,
    output logic [atan_pkg::ANGLE_W-1:0]  o_angle,
    output logic [atan_pkg::TERM_W-1:0]   o_terms
);
    localparam int DW = atan_pkg::DIV_W;
    localparam int AW = atan_pkg::ANGLE_W;

    logic [DATA_WIDTH-1:0] r_ax;
    logic                  r_neg;
    logic                  r_tneg;
    logic                  r_recip;
    logic [DW-1:0]         r_m;
    logic [DW-1:0]         r_x2;
    logic [AW-1:0]         r_sum;
    logic [17:0]           r_n;
    logic [AW-1:0]         r_angle;
    logic                  r_busy_q;
    logic [DW-1:0]         w_prod;
    logic [DW-1:0]         w_prod_wide;
    logic [DW-1:0]         w_odd_lo;
    logic [DW-1:0]         w_odd_hi;
    logic                  w_start;
    logic [DW-1:0]         w_num;
    logic [DW-1:0]         w_den;
    logic                  w_busy;
    logic [DW-1:0]         w_quot;
    logic [DATA_WIDTH-1:0] w_abs;
    logic [AW-1:0]         w_base;
    logic [AW-1:0]         w_mag;

    assign w_abs    = i_arg[DATA_WIDTH-1] ? (~i_arg + 1'b1) : i_arg;
    assign w_odd_lo = DW'({r_n, 1'b0}) - DW'(1);
    assign w_odd_hi = DW'({r_n, 1'b0}) + DW'(1);
    assign w_mag    = AW'(r_m);
    // magnitudes stay below 2^29 and x^2 below 2^28 in the direct series
    assign w_prod   = DW'(r_m[31:0]) * DW'(r_x2[31:0]);
    assign w_prod_wide = DW'(r_m[31:0]) * DW'(w_odd_lo[31:0]);

    always_comb begin
        w_start = 1'b0;
        w_num   = '0;
        w_den   = DW'(1);
        case (i_cmd.op)
            atan_pkg::OP_INIT: begin
                w_start = r_recip;
                w_num   = DW'(1) << 52;
                w_den   = DW'(r_ax);
            end
            atan_pkg::OP_DIVODD: begin
                w_start = 1'b1;
                w_num   = r_m;
                w_den   = w_odd_hi;
            end
            atan_pkg::OP_DIVX: begin
                w_start = 1'b1;
                w_num   = r_m << 24;
                w_den   = DW'(r_ax);
            end
            default: ;
        endcase
    end

    atan_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_busy),
        .o_quot  (w_quot)
    );

    assign w_base = r_neg ? (AW'(0) - atan_pkg::HALF_PI) : atan_pkg::HALF_PI;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            atan_pkg::OP_LOAD: begin
                r_ax    <= w_abs;
                r_neg   <= i_arg[DATA_WIDTH-1];
                r_tneg  <= i_arg[DATA_WIDTH-1];
                r_recip <= (DW'(w_abs) >= DW'(32'd16777216));
                r_sum   <= '0;
                r_n     <= '0;
            end
            atan_pkg::OP_SQR: begin
                r_x2 <= (DW'(r_ax) * DW'(r_ax)) >> 20;
            end
            atan_pkg::OP_INIT: begin
                if (!r_recip) begin
                    r_m <= DW'(r_ax) << 4;
                end
            end
            atan_pkg::OP_ADD: begin
                r_sum  <= r_tneg ? (r_sum - w_mag) : (r_sum + w_mag);
                r_n    <= r_n + 18'd1;
                r_tneg <= ~r_tneg;
            end
            atan_pkg::OP_MULX2: begin
                r_m <= w_prod >> 28;
            end
            atan_pkg::OP_MULODD: begin
                r_m <= w_prod_wide;
            end
            atan_pkg::OP_FINISH: begin
                r_angle <= r_recip ? (w_base - r_sum) : r_sum;
            end
            default: ;
        endcase
        if (!w_start && !w_busy && r_busy_q) begin
            r_m <= w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_q <= 1'b0;
        end else begin
            r_busy_q <= w_busy;
        end
    end

    // busy is extended by the registered copy r_busy_q while the quotient lands in r_m
    assign o_status.div_busy  = w_busy | r_busy_q;
    assign o_status.is_one    = !r_neg && (DW'(r_ax) == DW'(32'd16777216));
    assign o_status.recip     = r_recip;
    assign o_status.zero_arg  = 1'b0;
    assign o_status.above_tol = r_m > DW'(i_tol);
    assign o_angle            = r_angle;
    assign o_terms            = r_n[atan_pkg::TERM_W-1:0];
endmodule

FILE: rtl/core/atan_ctrl.sv
// arctangent controller: sequences the series iteration and the handshakes
module atan_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [atan_pkg::TERM_W-1:0] i_cap,
    input  logic [atan_pkg::TERM_W-1:0] i_terms,
    input  atan_pkg::t_status           i_status,
    output atan_pkg::t_cmd              o_cmd,
    output logic                        o_one,
    output logic                        o_capped
);
    typedef enum logic [3:0] {
        S_IDLE, S_SQR, S_INIT, S_WAIT0, S_CHECK, S_MULX2, S_MULODD,
        S_DIVODD, S_DIVX1, S_DIVX2, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   r_one;
    logic   r_capped;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_one       = r_one;
    assign o_capped    = r_capped;

    always_comb begin
        o_cmd.op = atan_pkg::OP_NONE;
        case (r_state)
            S_IDLE:   if (i_in_valid && o_in_ready) o_cmd.op = atan_pkg::OP_LOAD;
            S_SQR:    o_cmd.op = atan_pkg::OP_SQR;
            S_INIT:   o_cmd.op = atan_pkg::OP_INIT;
            S_CHECK: begin
                if (!i_status.div_busy && i_status.above_tol && i_terms < i_cap
                        && !i_status.is_one) begin
                    o_cmd.op = atan_pkg::OP_ADD;
                end
            end
            S_MULX2:  o_cmd.op = atan_pkg::OP_MULX2;
            S_MULODD: o_cmd.op = atan_pkg::OP_MULODD;
            S_DIVODD: if (!i_status.div_busy) o_cmd.op = atan_pkg::OP_DIVODD;
            S_DIVX1:  if (!i_status.div_busy) o_cmd.op = atan_pkg::OP_DIVX;
            S_DIVX2:  if (!i_status.div_busy) o_cmd.op = atan_pkg::OP_DIVX;
            S_FIN:    if (!i_status.div_busy) o_cmd.op = atan_pkg::OP_FINISH;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_one       <= 1'b0;
            r_capped    <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_in_valid && o_in_ready) r_state <= S_SQR;
                S_SQR:  r_state <= S_INIT;
                S_INIT: r_state <= S_WAIT0;
                S_WAIT0: r_state <= S_CHECK;
                S_CHECK: begin
                    if (!i_status.div_busy) begin
                        if (i_status.is_one || !i_status.above_tol) begin
                            r_capped <= 1'b0;
                            r_state  <= S_FIN;
                        end else if (i_terms >= i_cap) begin
                            r_capped <= 1'b1;
                            r_state  <= S_FIN;
                        end else if (i_status.recip) begin
                            r_state <= S_MULODD;
                        end else begin
                            r_state <= S_MULX2;
                        end
                    end
                end
                S_MULX2:  r_state <= S_MULODD;
                S_MULODD: r_state <= S_DIVODD;
                S_DIVODD: if (!i_status.div_busy)
                              r_state <= i_status.recip ? S_DIVX1 : S_WAIT0;
                S_DIVX1:  if (!i_status.div_busy) r_state <= S_DIVX2;
                S_DIVX2:  if (!i_status.div_busy) r_state <= S_WAIT0;
                S_FIN: begin
                    if (!i_status.div_busy) begin
                        r_one       <= i_status.is_one;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/core/arctangent_series_unit.sv
// arctangent series unit top level: config registers, controller and datapath
//
//  channel  | dir | contents
//  s_axis   | in  | arg_in
//  m_axis   | out | angle_out, terms_used, cap_reached
//  apb      | in  | tolerance (0x0), term_cap (0x4)
//
// an item's run time grows with the number of terms in either series and is
// set by the bit-serial divider (one division per direct term, three per
// reciprocal term plus one up front).
// reset is synchronous active low; config returns to 268 and 4096.
// a waiting result stalls the next item only until it is taken.
module arctangent_series_unit #(
    parameter int DATA_WIDTH = atan_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_WIDTH-1:0] s_axis_tdata,   // arg_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,   // angle_out, terms_used, cap_reached
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    logic [atan_pkg::TOL_W-1:0]   r_tol;
    logic [atan_pkg::TERM_W-1:0]  r_cap;
    atan_pkg::t_cmd               w_cmd;
    atan_pkg::t_status            w_status;
    logic [atan_pkg::ANGLE_W-1:0] w_angle;
    logic [atan_pkg::TERM_W-1:0]  w_terms;
    logic                         w_one;
    logic                         w_capped;
    logic [atan_pkg::ANGLE_W-1:0] w_angle_out;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= atan_pkg::TOL_RESET;
            r_cap <= atan_pkg::CAP_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                atan_pkg::REG_TOLERANCE: r_tol <= pwdata[atan_pkg::TOL_W-1:0];
                atan_pkg::REG_TERM_CAP:  r_cap <= pwdata[atan_pkg::TERM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            atan_pkg::REG_TOLERANCE: prdata = {3'd0, r_tol};
            default:                 prdata = {16'd0, r_cap};
        endcase
    end

    atan_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_cap       (r_cap),
        .i_terms     (w_terms),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_one       (w_one),
        .o_capped    (w_capped)
    );

    atan_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_arg    (s_axis_tdata),
        .i_tol    (r_tol),
        .o_angle  (w_angle),
        .o_terms  (w_terms)
    );

    assign w_angle_out  = w_one ? atan_pkg::QUARTER_PI : w_angle;
    assign m_axis_tdata = {1'b0, w_capped, w_terms, w_angle_out};
endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the arctangent series unit
`timescale 1ns / 1ps

module tb_top;

    localparam int  DW          = 32;
    localparam int  CYCLE_LIMIT = 6000000;
    localparam logic [DW-1:0] Q24_ONE = 32'h0100_0000;

    typedef struct packed {
        logic                         cap_hit;
        logic [atan_pkg::TERM_W-1:0]  n_terms;
        logic [atan_pkg::ANGLE_W-1:0] angle;
    } t_atan_res;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata;   // arg_in
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [47:0]   m_axis_tdata;   // angle_out, terms_used, cap_reached
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    logic [atan_pkg::TOL_W-1:0]  cur_tol;
    logic [atan_pkg::TERM_W-1:0] cur_cap;
    t_atan_res         angle_q[$];
    int                err_cnt;
    int                send_idle_pct;
    int                recv_stall_pct;
    longint            cycle_cnt;

    arctangent_series_unit #(.DATA_WIDTH(DW)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // series arctangent in Q2.28 with the current tolerance and term cap
    function automatic t_atan_res calc_atan(input logic [DW-1:0] arg);
        t_atan_res    r;
        logic         neg;
        logic [DW-1:0] a_abs;
        logic [63:0]  ax;
        logic [63:0]  m;
        logic [63:0]  n;
        logic [63:0]  x2;
        longint       sum;
        longint       angle;
        logic         tneg;
        logic         capped;
        logic         recip;
        neg    = arg[DW-1];
        a_abs  = neg ? (~arg + 1'b1) : arg;
        ax     = 64'(a_abs);
        sum    = 0;
        n      = 0;
        tneg   = neg;
        capped = 1'b0;
        if (!neg && ax == 64'(Q24_ONE)) begin
            r.angle   = atan_pkg::QUARTER_PI;
            r.n_terms = '0;
            r.cap_hit = 1'b0;
            return r;
        end
        recip = (ax >= 64'(Q24_ONE));
        m     = recip ? (64'd1 << 52) / ax : (ax << 4);
        x2    = (ax * ax) >> 20;
        while (m > 64'(cur_tol)) begin
            if (n >= 64'(cur_cap)) begin
                capped = 1'b1;
                break;
            end
            sum = tneg ? sum - longint'(m) : sum + longint'(m);
            n   = n + 1;
            if (recip) begin
                m = m * (2 * n - 1) / (2 * n + 1);
                m = (m << 24) / ax;
                m = (m << 24) / ax;
            end else begin
                m = ((m * x2) >> 28) * (2 * n - 1) / (2 * n + 1);
            end
            tneg = !tneg;
        end
        if (recip)
            angle = (neg ? -longint'(atan_pkg::HALF_PI) : longint'(atan_pkg::HALF_PI)) - sum;
        else
            angle = sum;
        r.angle   = angle[atan_pkg::ANGLE_W-1:0];
        r.n_terms = n[atan_pkg::TERM_W-1:0];
        r.cap_hit = capped;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        err_cnt++;
    endtask

    // result beat checker and receiver stall
    always @(posedge i_clk) begin
        t_atan_res want;
        t_atan_res got;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[46:0];
            if (angle_q.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata, 0);
            end else begin
                want = angle_q.pop_front();
                if (got.angle !== want.angle)
                    report_mismatch("angle_out", got.angle, want.angle);
                if (got.n_terms !== want.n_terms)
                    report_mismatch("terms_used", got.n_terms, want.n_terms);
                if (got.cap_hit !== want.cap_hit)
                    report_mismatch("cap_reached", got.cap_hit, want.cap_hit);
                if (m_axis_tdata[47] !== 1'b0)
                    report_mismatch("pad bit", m_axis_tdata[47], 0);
            end
        end
    end

    task automatic send_arg(input logic [DW-1:0] arg);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= arg;
        do @(posedge i_clk); while (!s_axis_tready);
        angle_q.push_back(calc_atan(arg));
    endtask

    task automatic wait_drain();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (angle_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [0:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == atan_pkg::REG_TOLERANCE) cur_tol = val[atan_pkg::TOL_W-1:0];
        else cur_cap = val[atan_pkg::TERM_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [31:0] tol, input logic [31:0] cap);
        apb_write(atan_pkg::REG_TOLERANCE, tol);
        apb_write(atan_pkg::REG_TERM_CAP, cap);
    endtask

    function automatic logic [DW-1:0] rand_arg();
        logic [DW-1:0] v;
        v = $urandom;
        case ($urandom_range(3))
            0: v = v;
            1: v = 32'($signed(v[24:0]));
            2: v = ($urandom_range(1) ? Q24_ONE : -Q24_ONE) + 32'($signed(v[19:0]));
            default: v = {v[31], {7{~v[31]}}, v[23:0]} ^ {1'b0, v[30:24], 24'd0};
        endcase
        return v;
    endfunction

    task automatic test_directed();
        logic [DW-1:0] args[$];
        // reset register values first, only quickly converging arguments
        send_arg('0);
        send_arg(Q24_ONE);
        send_arg(32'h0000_0001);
        send_arg(32'hFFFF_FFFF);
        send_arg(32'h7FFF_FFFF);
        send_arg(32'h8000_0000);
        wait_drain();
        set_regs(268, 16);
        args = '{32'h0000_0000, Q24_ONE, -Q24_ONE, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h00FF_FFFF, 32'hFF00_0001, Q24_ONE + 1, -Q24_ONE - 1,
                 32'h0080_0000, 32'hFF80_0000, 32'h0200_0000};
        foreach (args[i]) send_arg(args[i]);
        wait_drain();
    endtask

    task automatic test_register_extremes();
        set_regs(0, 12);
        send_arg(32'h0040_0000);
        send_arg(32'h0000_0001);
        send_arg(-Q24_ONE);
        send_arg(32'h7FFF_FFFF);
        wait_drain();
        set_regs(268, 0);
        send_arg(32'h0080_0000);
        send_arg(32'hF000_0000);
        send_arg('0);
        wait_drain();
        set_regs(32'h1000_0000, 32'h0000_FFFF);
        send_arg(32'h00FF_FFFF);
        send_arg(32'h8000_0000);
        send_arg(-Q24_ONE);
        wait_drain();
        set_regs(1, 10);
        send_arg(32'h00C0_0000);
        send_arg(-Q24_ONE);
        send_arg(32'h7FFF_FFFF);
        wait_drain();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int cnt);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < cnt; k++) begin
            // fresh register setting every so often, kept small so items stay short
            if (k % 35 == 0) begin
                wait_drain();
                set_regs($urandom_range(1) ? $urandom_range(4000) : $urandom_range(300),
                         $urandom_range(1, 12));
            end
            send_arg(rand_arg());
        end
        wait_drain();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cur_tol        = atan_pkg::TOL_RESET;
        cur_cap        = atan_pkg::CAP_RESET;
        err_cnt        = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycle_cnt      = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_extremes();
        test_random(0, 0, 140);
        test_random(61, 0, 130);
        test_random(0, 61, 130);
        test_random(14, 14, 130);
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0 && angle_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/atan_pkg.sv
rtl/core/atan_div.sv
rtl/core/atan_datapath.sv
rtl/core/atan_ctrl.sv
rtl/core/arctangent_series_unit.sv
sim/tb_top.sv
